[hdl/vau_pkg.sv]
// Shared types and constants of the four-component vector arithmetic unit.
// Depends on nothing; every other file but vau_sqrt and the port checks imports it.
package vau_pkg;

  localparam int unsigned VAU_LANES = 4;

  typedef enum logic [3:0] {
    CMD_ADD   = 4'd0,
    CMD_SUB   = 4'd1,
    CMD_NEG   = 4'd2,
    CMD_SCALE = 4'd3,
    CMD_DIV   = 4'd4,
    CMD_DOT   = 4'd5,
    CMD_CROSS = 4'd6,
    CMD_MAG   = 4'd7,
    CMD_NORM  = 4'd8
  } vau_cmd_e;

  // Command and saturation status that travel with every word.
  typedef struct packed {
    vau_cmd_e cmd;
    logic     ovf;
  } vau_tag_t;

endpackage

[hdl/vector4_arithmetic_unit.sv]
// Top level of the four-component vector arithmetic unit in signed fixed point.
// Depends on vau_pkg, vau_front, vau_sqrt, vau_div and vau_back.
//
// Usage
//   One input word carries a command, two vectors a and b and a scalar. It
//   is taken at a rising edge where in_valid_i is high and in_stall_o is
//   low. Every input word gives exactly one result word, offered on
//   out_valid_o and taken at an edge where out_stall_i is low.
// Throughput and stages
//   A new word can be taken in every cycle while the pipeline is not
//   held. Each word passes through all stages whatever its command: four
//   front stages (input, multiply, combine, saturate), COMPONENT_WIDTH + 1
//   square-root stages (one root bit each), COMPONENT_WIDTH + FRAC_BITS
//   divider stages (one quotient bit each) and the output register.
// Stalls
//   When the receiver stalls, the pipeline keeps running until a word
//   finds the output register occupied; it then parks in a skid register
//   and the whole pipeline, input included, holds. in_stall_o is a plain
//   register output, so nothing is lost or repeated.
// Reset
//   rst_ni clears all valid bits and the skid-full flag; the data registers
//   need no reset, so the block is ready as soon as reset is released.
module vector4_arithmetic_unit
  import vau_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = 32,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [3:0]                        command_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] scalar_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COMPONENT_WIDTH-1:0] r_x_o,
  output logic signed [COMPONENT_WIDTH-1:0] r_y_o,
  output logic signed [COMPONENT_WIDTH-1:0] r_z_o,
  output logic signed [COMPONENT_WIDTH-1:0] r_w_o,
  output logic signed [COMPONENT_WIDTH-1:0] scalar_out_o,
  output logic                              overflow_o,
  output logic                              divide_by_zero_o
);

  localparam int unsigned W  = COMPONENT_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned QW = W + F;

  // Everything the square-root stages carry past themselves.
  typedef struct packed {
    vau_tag_t                    tag;
    logic [VAU_LANES-1:0][W-1:0] a;
    logic [VAU_LANES-1:0][W-1:0] amag;
    logic [VAU_LANES-1:0][W-1:0] r;
    logic [W-1:0]                sc;
    logic [W-1:0]                sabs;
    logic                        sneg;
    logic                        szero;
  } sb1_t;

  // Everything the divider stages carry past themselves.
  typedef struct packed {
    vau_tag_t                    tag;
    logic [VAU_LANES-1:0][W-1:0] a;
    logic [VAU_LANES-1:0][W-1:0] r;
    logic [W-1:0]                sc;
    logic [W:0]                  root;
    logic                        dneg;
    logic                        szero;
  } sb2_t;

  localparam int unsigned SB1_W = $bits(sb1_t);
  localparam int unsigned SB2_W = $bits(sb2_t);

  logic                         en;
  logic                         fe_valid, sq_valid, dv_valid;
  sb1_t                         sb1_in, sb1_out;
  sb2_t                         sb2_in, sb2_out;
  logic [SB1_W-1:0]             sb1_vec;
  logic [SB2_W-1:0]             sb2_vec;
  logic [2*W:0]                 fe_sq;
  logic [W:0]                   root;
  logic [W:0]                   den;
  logic [VAU_LANES-1:0][QW-1:0] quo;
  logic [VAU_LANES-1:0][W-1:0]  a_vec, b_vec, r_vec;

  assign a_vec = {a_w_i, a_z_i, a_y_i, a_x_i};
  assign b_vec = {b_w_i, b_z_i, b_y_i, b_x_i};

  // A word enters whenever the pipeline is moving.
  assign in_stall_o = !en;

  vau_front #(
    .W (W),
    .F (F)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cmd_i   (vau_cmd_e'(command_i)),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .s_i     (scalar_in_i),
    .valid_o (fe_valid),
    .tag_o   (sb1_in.tag),
    .a_o     (sb1_in.a),
    .amag_o  (sb1_in.amag),
    .r_o     (sb1_in.r),
    .sc_o    (sb1_in.sc),
    .sq_o    (fe_sq),
    .sabs_o  (sb1_in.sabs),
    .sneg_o  (sb1_in.sneg),
    .szero_o (sb1_in.szero)
  );

  assign sb1_vec = sb1_in;

  vau_sqrt #(
    .IW   (2 * W + 1),
    .RW   (W + 1),
    .SB_W (SB1_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_valid),
    .sq_i    (fe_sq),
    .sb_i    (sb1_vec),
    .valid_o (sq_valid),
    .root_o  (root),
    .sb_o    (sb1_out)
  );

  // Normalise divides by the length; divide uses the scalar's magnitude.
  assign den = (sb1_out.tag.cmd == CMD_NORM) ? root : {1'b0, sb1_out.sabs};

  assign sb2_in.tag   = sb1_out.tag;
  assign sb2_in.a     = sb1_out.a;
  assign sb2_in.r     = sb1_out.r;
  assign sb2_in.sc    = sb1_out.sc;
  assign sb2_in.root  = root;
  assign sb2_in.dneg  = sb1_out.sneg && (sb1_out.tag.cmd == CMD_DIV);
  assign sb2_in.szero = sb1_out.szero;
  assign sb2_vec      = sb2_in;

  vau_div #(
    .NW   (W),
    .F    (F),
    .DW   (W + 1),
    .SB_W (SB2_W),
    .QW   (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .num_i   (sb1_out.amag),
    .den_i   (den),
    .sb_i    (sb2_vec),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .sb_o    (sb2_out)
  );

  vau_back #(
    .W  (W),
    .QW (QW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dv_valid),
    .quo_i       (quo),
    .tag_i       (sb2_out.tag),
    .a_i         (sb2_out.a),
    .r_i         (sb2_out.r),
    .sc_i        (sb2_out.sc),
    .root_i      (sb2_out.root),
    .dneg_i      (sb2_out.dneg),
    .szero_i     (sb2_out.szero),
    .out_stall_i (out_stall_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .r_o         (r_vec),
    .sc_o        (scalar_out_o),
    .ovf_o       (overflow_o),
    .dz_o        (divide_by_zero_o)
  );

  assign r_x_o = r_vec[0];
  assign r_y_o = r_vec[1];
  assign r_z_o = r_vec[2];
  assign r_w_o = r_vec[3];

endmodule

[hdl/vau_front.sv]
// Front end: input register, product stage, combining stage and saturation.
// Depends on vau_pkg.
module vau_front
  import vau_pkg::*;
#(
  parameter int unsigned W = 32,
  parameter int unsigned F = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  vau_cmd_e                        cmd_i,
  input  logic [VAU_LANES-1:0][W-1:0]     a_i,
  input  logic [VAU_LANES-1:0][W-1:0]     b_i,
  input  logic [W-1:0]                    s_i,
  output logic                            valid_o,
  output vau_tag_t                        tag_o,
  output logic [VAU_LANES-1:0][W-1:0]     a_o,
  output logic [VAU_LANES-1:0][W-1:0]     amag_o,
  output logic [VAU_LANES-1:0][W-1:0]     r_o,
  output logic [W-1:0]                    sc_o,
  output logic [2*W:0]                    sq_o,
  output logic [W-1:0]                    sabs_o,
  output logic                            sneg_o,
  output logic                            szero_o
);

  localparam int unsigned PW = 2 * W;
  localparam int unsigned VW = 2 * W + 2;
  localparam int unsigned NP = 7;
  localparam logic [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX = $signed({{(VW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [VW-1:0] VMIN = $signed({{(VW-W+1){1'b1}}, {(W-1){1'b0}}});

  // Returns the overflow flag above the clamped component.
  function automatic logic [W:0] sat_f(input logic signed [VW-1:0] v);
    logic [W:0] res;
    if (v > VMAX) begin
      res = {1'b1, CMAX};
    end else if (v < VMIN) begin
      res = {1'b1, CMIN};
    end else begin
      res = {1'b0, v[W-1:0]};
    end
    return res;
  endfunction

  // Stage 1: registered inputs.
  logic                        v1_q;
  vau_cmd_e                    cmd1_q;
  logic [VAU_LANES-1:0][W-1:0] a1_q, b1_q;
  logic [W-1:0]                s1_q;

  // Stage 2: products.
  logic                        v2_q;
  vau_cmd_e                    cmd2_q;
  logic [VAU_LANES-1:0][W-1:0] a2_q, b2_q;
  logic [W-1:0]                s2_q;
  logic signed [PW-1:0]        p2_q [NP];
  logic signed [PW-1:0]        p2_d [NP];
  logic signed [W-1:0]         ma [NP];
  logic signed [W-1:0]         mb [NP];

  // Stage 3: exact lane values before saturation.
  logic                        v3_q;
  vau_cmd_e                    cmd3_q;
  logic [VAU_LANES-1:0][W-1:0] a3_q;
  logic [W-1:0]                s3_q;
  logic signed [VW-1:0]        x3_q [VAU_LANES];
  logic signed [VW-1:0]        x3_d [VAU_LANES];
  logic signed [VW-1:0]        dw3_q, dw3_d, sum_d;
  logic [2*W:0]                sq3_q;

  // Stage 4: saturated results.
  logic                        v4_q;
  vau_tag_t                    tag4_q;
  logic [VAU_LANES-1:0][W-1:0] a4_q, amag4_q, r4_q;
  logic [W-1:0]                sc4_q, sabs4_q;
  logic                        sneg4_q, szero4_q;
  logic [2*W:0]                sq4_q;

  logic [VAU_LANES-1:0][W-1:0] r4_d, amag4_d;
  logic [W:0]                  lane_sat [VAU_LANES];
  logic [W:0]                  sc_sat;
  logic                        ovf4_d;

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    for (int i = 0; i < VAU_LANES; i++) begin
      ma[i] = $signed(a1_q[i]);
      mb[i] = $signed(s1_q);
    end
    unique case (cmd1_q)
      CMD_DOT: begin
        for (int i = 0; i < VAU_LANES; i++) mb[i] = $signed(b1_q[i]);
      end
      CMD_MAG, CMD_NORM: begin
        for (int i = 0; i < VAU_LANES; i++) mb[i] = $signed(a1_q[i]);
      end
      CMD_CROSS: begin
        ma[0] = $signed(a1_q[1]); mb[0] = $signed(b1_q[2]);
        ma[1] = $signed(a1_q[2]); mb[1] = $signed(b1_q[0]);
        ma[2] = $signed(a1_q[0]); mb[2] = $signed(b1_q[1]);
        ma[4] = $signed(a1_q[2]); mb[4] = $signed(b1_q[1]);
        ma[5] = $signed(a1_q[0]); mb[5] = $signed(b1_q[2]);
        ma[6] = $signed(a1_q[1]); mb[6] = $signed(b1_q[0]);
      end
      default: ;
    endcase
    for (int i = 0; i < NP; i++) p2_d[i] = ma[i] * mb[i];
  end

  always_comb begin
    sum_d = VW'(p2_q[0]) + VW'(p2_q[1]) + VW'(p2_q[2]) + VW'(p2_q[3]);
    dw3_d = '0;
    for (int i = 0; i < VAU_LANES; i++) x3_d[i] = '0;
    unique case (cmd2_q)
      CMD_ADD: begin
        for (int i = 0; i < VAU_LANES; i++) begin
          x3_d[i] = VW'($signed(a2_q[i])) + VW'($signed(b2_q[i]));
        end
      end
      CMD_SUB: begin
        for (int i = 0; i < VAU_LANES; i++) begin
          x3_d[i] = VW'($signed(a2_q[i])) - VW'($signed(b2_q[i]));
        end
      end
      CMD_NEG: begin
        for (int i = 0; i < VAU_LANES; i++) x3_d[i] = -VW'($signed(a2_q[i]));
      end
      CMD_SCALE: begin
        for (int i = 0; i < VAU_LANES; i++) x3_d[i] = VW'(p2_q[i]) >>> F;
      end
      CMD_DOT: dw3_d = sum_d >>> F;
      CMD_CROSS: begin
        x3_d[0] = (VW'(p2_q[0]) - VW'(p2_q[4])) >>> F;
        x3_d[1] = (VW'(p2_q[1]) - VW'(p2_q[5])) >>> F;
        x3_d[2] = (VW'(p2_q[2]) - VW'(p2_q[6])) >>> F;
      end
      default: ;
    endcase
  end

  always_comb begin
    ovf4_d = 1'b0;
    for (int i = 0; i < VAU_LANES; i++) begin
      lane_sat[i] = sat_f(x3_q[i]);
      r4_d[i]     = lane_sat[i][W-1:0];
      ovf4_d      = ovf4_d | lane_sat[i][W];
      amag4_d[i]  = a3_q[i][W-1] ? (~a3_q[i] + W'(1)) : a3_q[i];
    end
    sc_sat = sat_f(dw3_q);
    ovf4_d = ovf4_d | sc_sat[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd1_q <= cmd_i;
      a1_q   <= a_i;
      b1_q   <= b_i;
      s1_q   <= s_i;

      cmd2_q <= cmd1_q;
      a2_q   <= a1_q;
      b2_q   <= b1_q;
      s2_q   <= s1_q;
      for (int i = 0; i < NP; i++) p2_q[i] <= p2_d[i];

      cmd3_q <= cmd2_q;
      a3_q   <= a2_q;
      s3_q   <= s2_q;
      for (int i = 0; i < VAU_LANES; i++) x3_q[i] <= x3_d[i];
      dw3_q  <= dw3_d;
      sq3_q  <= sum_d[2*W:0];

      tag4_q.cmd <= cmd3_q;
      tag4_q.ovf <= ovf4_d;
      a4_q     <= a3_q;
      amag4_q  <= amag4_d;
      r4_q     <= r4_d;
      sc4_q    <= sc_sat[W-1:0];
      sabs4_q  <= s3_q[W-1] ? (~s3_q + W'(1)) : s3_q;
      sneg4_q  <= s3_q[W-1];
      szero4_q <= (s3_q == '0);
      sq4_q    <= sq3_q;
    end
  end

  assign valid_o = v4_q;
  assign tag_o   = tag4_q;
  assign a_o     = a4_q;
  assign amag_o  = amag4_q;
  assign r_o     = r4_q;
  assign sc_o    = sc4_q;
  assign sq_o    = sq4_q;
  assign sabs_o  = sabs4_q;
  assign sneg_o  = sneg4_q;
  assign szero_o = szero4_q;

endmodule

[hdl/vau_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
// Depends on nothing; carries an opaque sideband word alongside.
module vau_sqrt #(
  parameter int unsigned IW   = 65,
  parameter int unsigned RW   = 33,
  parameter int unsigned SB_W = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [IW-1:0]   sq_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SB_W-1:0] sb_o
);

  localparam int unsigned TW = IW + 2;

  logic            vld_q  [RW];
  logic [IW-1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [SB_W-1:0] sb_q   [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int unsigned K = RW - 1 - j;
    logic            v_in;
    logic [IW-1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [SB_W-1:0] sb_in;
    logic [TW-1:0]   trial;
    logic            ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = sq_i;
      assign root_in = '0;
      assign sb_in   = sb_i;
    end else begin : g_next
      assign v_in    = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign sb_in   = sb_q[j-1];
    end

    // Root bits below K are still zero, so the OR forms 2*root*2^K + 4^K.
    assign trial = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
    assign ge    = TW'(rem_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (rem_in - trial[IW-1:0]) : rem_in;
        root_q[j] <= root_in | (ge ? (RW'(1) << K) : '0);
        sb_q[j]   <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

endmodule

[hdl/vau_div.sv]
// Four-lane pipelined restoring divider, one quotient bit per stage.
// Depends on vau_pkg; carries an opaque sideband word alongside.
module vau_div
  import vau_pkg::*;
#(
  parameter int unsigned NW   = 32,
  parameter int unsigned F    = 16,
  parameter int unsigned DW   = 33,
  parameter int unsigned SB_W = 8,
  parameter int unsigned QW   = NW + F
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [VAU_LANES-1:0][NW-1:0] num_i,
  input  logic [DW-1:0]                den_i,
  input  logic [SB_W-1:0]              sb_i,
  output logic                         valid_o,
  output logic [VAU_LANES-1:0][QW-1:0] quo_o,
  output logic [SB_W-1:0]              sb_o
);

  logic                         vld_q [QW];
  logic [VAU_LANES-1:0][NW-1:0] num_q [QW];
  logic [DW-1:0]                den_q [QW];
  logic [VAU_LANES-1:0][DW-1:0] rem_q [QW];
  logic [VAU_LANES-1:0][QW-1:0] quo_q [QW];
  logic [SB_W-1:0]              sb_q  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int unsigned BIT = QW - 1 - j;
    logic                         v_in;
    logic [VAU_LANES-1:0][NW-1:0] num_in;
    logic [DW-1:0]                den_in;
    logic [VAU_LANES-1:0][DW-1:0] rem_in;
    logic [VAU_LANES-1:0][QW-1:0] quo_in;
    logic [SB_W-1:0]              sb_in;
    logic [VAU_LANES-1:0][DW-1:0] rem_d;
    logic [VAU_LANES-1:0][QW-1:0] quo_d;
    logic [VAU_LANES-1:0]         nbit;

    if (j == 0) begin : g_first
      assign v_in   = valid_i;
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign v_in   = vld_q[j-1];
      assign num_in = num_q[j-1];
      assign den_in = den_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign sb_in  = sb_q[j-1];
    end

    // The dividend is the numerator shifted up by the fraction width.
    for (genvar l = 0; l < VAU_LANES; l++) begin : g_lane
      if (BIT >= F) begin : g_num
        assign nbit[l] = num_in[l][BIT-F];
      end else begin : g_pad
        assign nbit[l] = 1'b0;
      end
    end

    always_comb begin
      logic [DW:0] t;
      logic        ge;
      for (int l = 0; l < VAU_LANES; l++) begin
        t  = {rem_in[l], nbit[l]};
        ge = t >= {1'b0, den_in};
        rem_d[l]      = ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
        quo_d[l]      = quo_in[l];
        quo_d[l][BIT] = ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[j] <= num_in;
        den_q[j] <= den_in;
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        sb_q[j]  <= sb_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign sb_o    = sb_q[QW-1];

endmodule

[hdl/vau_back.sv]
// Back end: final result selection, output register and skid register.
// Depends on vau_pkg.
module vau_back
  import vau_pkg::*;
#(
  parameter int unsigned W  = 32,
  parameter int unsigned QW = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [VAU_LANES-1:0][QW-1:0] quo_i,
  input  vau_tag_t                     tag_i,
  input  logic [VAU_LANES-1:0][W-1:0]  a_i,
  input  logic [VAU_LANES-1:0][W-1:0]  r_i,
  input  logic [W-1:0]                 sc_i,
  input  logic [W:0]                   root_i,
  input  logic                         dneg_i,
  input  logic                         szero_i,
  input  logic                         out_stall_i,
  output logic                         en_o,
  output logic                         out_valid_o,
  output logic [VAU_LANES-1:0][W-1:0]  r_o,
  output logic [W-1:0]                 sc_o,
  output logic                         ovf_o,
  output logic                         dz_o
);

  localparam logic [W-1:0]  CMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  CMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [QW-1:0] QPOS  = {{(QW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [QW-1:0] QNEG  = {{(QW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]    RTMAX = {2'b00, {(W-1){1'b1}}};

  typedef struct packed {
    logic [VAU_LANES-1:0][W-1:0] r;
    logic [W-1:0]                sc;
    logic                        ovf;
    logic                        dz;
  } word_t;

  word_t fin, out_q, skid_q;
  logic  out_v_q, skid_full_q;

  always_comb begin
    logic neg;
    fin.r   = r_i;
    fin.sc  = sc_i;
    fin.ovf = tag_i.ovf;
    fin.dz  = 1'b0;
    for (int l = 0; l < VAU_LANES; l++) begin
      neg = a_i[l][W-1] ^ dneg_i;
      if (tag_i.cmd == CMD_DIV && szero_i) begin
        fin.dz = 1'b1;
        if (a_i[l][W-1]) begin
          fin.r[l] = CMIN;
        end else if (a_i[l] != '0) begin
          fin.r[l] = CMAX;
        end else begin
          fin.r[l] = '0;
        end
      end else if (tag_i.cmd == CMD_NORM && root_i == '0) begin
        fin.r[l] = a_i[l];
      end else if (tag_i.cmd == CMD_DIV || tag_i.cmd == CMD_NORM) begin
        if (!neg && quo_i[l] > QPOS) begin
          fin.r[l] = CMAX;
          fin.ovf  = 1'b1;
        end else if (neg && quo_i[l] > QNEG) begin
          fin.r[l] = CMIN;
          fin.ovf  = 1'b1;
        end else if (neg) begin
          fin.r[l] = ~quo_i[l][W-1:0] + W'(1);
        end else begin
          fin.r[l] = quo_i[l][W-1:0];
        end
      end
    end
    if (tag_i.cmd == CMD_MAG) begin
      if (root_i > RTMAX) begin
        fin.sc  = CMAX;
        fin.ovf = 1'b1;
      end else begin
        fin.sc = root_i[W-1:0];
      end
    end
  end

  // The pipeline moves while the skid register is free.
  assign en_o = !skid_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q     <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (!skid_full_q) begin
      if (!out_v_q || !out_stall_i) begin
        out_v_q <= valid_i;
      end else if (valid_i) begin
        skid_full_q <= 1'b1;
      end
    end else if (!out_stall_i) begin
      skid_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      if (!out_v_q || !out_stall_i) begin
        out_q <= fin;
      end else if (valid_i) begin
        skid_q <= fin;
      end
    end else if (!out_stall_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign r_o         = out_q.r;
  assign sc_o        = out_q.sc;
  assign ovf_o       = out_q.ovf;
  assign dz_o        = out_q.dz;

endmodule

[hdl/vau_checker.sv]
// Port-level checks of the vector arithmetic unit, bound to its top level.
// Depends on vector4_arithmetic_unit.
module vau_port_checks #(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [COMPONENT_WIDTH-1:0] r_x_o,
  input logic [COMPONENT_WIDTH-1:0] scalar_out_o,
  input logic                       overflow_o,
  input logic                       divide_by_zero_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(r_x_o) && $stable(scalar_out_o)
      && $stable(overflow_o))
    else $error("stalled result word changed");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(divide_by_zero_o && overflow_o))
    else $error("divide by zero reported together with overflow");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

endmodule

bind vector4_arithmetic_unit vau_port_checks #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_vau_port_checks (.*);

[sim/vau_checker.sv]
// Scoreboard for the vector arithmetic unit: predicts each result word from
// the accepted input word and compares it field by field. Depends on vau_pkg.
`timescale 1ns / 100ps

module vau_checker
  import vau_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [3:0]         command_i,
  input  logic signed [31:0] a_x_i, a_y_i, a_z_i, a_w_i,
  input  logic signed [31:0] b_x_i, b_y_i, b_z_i, b_w_i,
  input  logic signed [31:0] scalar_in_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] r_x_i, r_y_i, r_z_i, r_w_i,
  input  logic signed [31:0] scalar_out_i,
  input  logic               overflow_i,
  input  logic               divide_by_zero_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [31:0] r[4];
    logic [31:0] sc;
    logic        ovf;
    logic        dz;
  } vec_result_t;

  localparam wide_t QMAX = 128'sd2147483647;
  localparam wide_t QMIN = -QMAX - 128'sd1;

  vec_result_t results_due[$];

  function automatic logic [31:0] clamp_q(input wide_t v, inout logic ovf);
    if (v > QMAX) begin
      ovf = 1'b1;
      return QMAX[31:0];
    end
    if (v < QMIN) begin
      ovf = 1'b1;
      return QMIN[31:0];
    end
    return v[31:0];
  endfunction

  function automatic wide_t widen(input logic signed [31:0] x);
    wide_t v;
    v = x;
    return v;
  endfunction

  function automatic wide_t root_floor(input wide_t sum);
    logic [63:0]  r, c;
    logic [127:0] sq;
    r = '0;
    for (int i = 62; i >= 0; i--) begin
      c  = r | (64'd1 << i);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= sum) r = c;
    end
    return wide_t'({64'd0, r});
  endfunction

  function automatic vec_result_t vec_predict(input logic [3:0] cmd,
                                              input logic signed [31:0] a[4],
                                              input logic signed [31:0] b[4],
                                              input logic signed [31:0] s);
    vec_result_t e;
    wide_t       wa[4], wb[4], ws, acc, len;
    e.r = '{default: '0};
    e.sc = '0;
    e.ovf = 1'b0;
    e.dz = 1'b0;
    for (int i = 0; i < 4; i++) begin
      wa[i] = widen(a[i]);
      wb[i] = widen(b[i]);
    end
    ws = widen(s);
    case (cmd)
      CMD_ADD:   for (int i = 0; i < 4; i++) e.r[i] = clamp_q(wa[i] + wb[i], e.ovf);
      CMD_SUB:   for (int i = 0; i < 4; i++) e.r[i] = clamp_q(wa[i] - wb[i], e.ovf);
      CMD_NEG:   for (int i = 0; i < 4; i++) e.r[i] = clamp_q(-wa[i], e.ovf);
      CMD_SCALE: for (int i = 0; i < 4; i++) e.r[i] = clamp_q((wa[i] * ws) >>> 16, e.ovf);
      CMD_DIV: begin
        if (ws == 0) begin
          // A zero divisor saturates towards the sign of each component.
          e.dz = 1'b1;
          for (int i = 0; i < 4; i++)
            e.r[i] = (wa[i] > 0) ? QMAX[31:0] : (wa[i] < 0) ? QMIN[31:0] : 32'd0;
        end else begin
          for (int i = 0; i < 4; i++) e.r[i] = clamp_q((wa[i] <<< 16) / ws, e.ovf);
        end
      end
      CMD_DOT: begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += wa[i] * wb[i];
        e.sc = clamp_q(acc >>> 16, e.ovf);
      end
      CMD_CROSS: begin
        e.r[0] = clamp_q((wa[1] * wb[2] - wa[2] * wb[1]) >>> 16, e.ovf);
        e.r[1] = clamp_q((wa[2] * wb[0] - wa[0] * wb[2]) >>> 16, e.ovf);
        e.r[2] = clamp_q((wa[0] * wb[1] - wa[1] * wb[0]) >>> 16, e.ovf);
      end
      CMD_MAG, CMD_NORM: begin
        acc = 0;
        for (int i = 0; i < 4; i++) acc += wa[i] * wa[i];
        len = root_floor(acc);
        if (cmd == CMD_MAG) e.sc = clamp_q(len, e.ovf);
        else if (len == 0) for (int i = 0; i < 4; i++) e.r[i] = a[i];
        else for (int i = 0; i < 4; i++) e.r[i] = clamp_q((wa[i] <<< 16) / len, e.ovf);
      end
      default: ;
    endcase
    return e;
  endfunction

  function automatic int field_diff(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] act_v);
    if (exp_v === act_v) return 0;
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    return 1;
  endfunction

  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    vec_result_t e;
    if (!rst_ni) begin
      results_due.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        results_due.push_back(vec_predict(command_i, '{a_x_i, a_y_i, a_z_i, a_w_i},
                                          '{b_x_i, b_y_i, b_z_i, b_w_i}, scalar_in_i));
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: result word with none expected, got r %h %h %h %h s %h",
                   $time, r_x_i, r_y_i, r_z_i, r_w_i, scalar_out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = results_due.pop_front();
          fail_count_o <= fail_count_o + field_diff("r_x", e.r[0], r_x_i)
                        + field_diff("r_y", e.r[1], r_y_i) + field_diff("r_z", e.r[2], r_z_i)
                        + field_diff("r_w", e.r[3], r_w_i)
                        + field_diff("scalar_out", e.sc, scalar_out_i)
                        + field_diff("overflow", e.ovf, overflow_i)
                        + field_diff("divide_by_zero", e.dz, divide_by_zero_i);
        end
      end
    end
    pending_o = results_due.size();
  end

endmodule

[sim/vector4_arithmetic_unit_tb.sv]
// Testbench top for the vector arithmetic unit: drives input words, stalls
// the result side and gives the verdict. Depends on vau_pkg, vau_checker and the unit.
`timescale 1ns / 100ps

module vector4_arithmetic_unit_tb;
  import vau_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         command_i = '0;
  logic signed [31:0] a_x_i = '0, a_y_i = '0, a_z_i = '0, a_w_i = '0;
  logic signed [31:0] b_x_i = '0, b_y_i = '0, b_z_i = '0, b_w_i = '0;
  logic signed [31:0] scalar_in_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic signed [31:0] r_x_o, r_y_o, r_z_o, r_w_o, scalar_out_o;
  logic               overflow_o, divide_by_zero_o;
  int                 fail_count, pending_words;

  // Idling odds in percent for either side, and a request for a long
  // receiver hold-off that the stall process serves on its own.
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 67;
  bit          hold_off_req = 1'b0;
  int          quiet_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  vector4_arithmetic_unit DUT (.*);

  vau_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i,
    .a_x_i, .a_y_i, .a_z_i, .a_w_i, .b_x_i, .b_y_i, .b_z_i, .b_w_i, .scalar_in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .r_x_i(r_x_o), .r_y_i(r_y_o),
    .r_z_i(r_z_o), .r_w_i(r_w_o), .scalar_out_i(scalar_out_o),
    .overflow_i(overflow_o), .divide_by_zero_i(divide_by_zero_o),
    .fail_count_o(fail_count), .pending_o(pending_words)
  );

  // The receiver decides its stall at every falling edge. A hold-off keeps
  // the output stalled long enough for the whole pipeline to fill and push
  // back on the input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // The watchdog counts edges at which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one word from a falling edge and holds it until the block takes
  // it. The stall output is a register, so its value at the falling edge is
  // the one seen at the next rising edge.
  task automatic send_word(input logic [3:0] cmd, input logic [31:0] ax, ay, az, aw,
                           input logic [31:0] bx, by, bz, bw, input logic [31:0] s);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    command_i = cmd;
    a_x_i = ax; a_y_i = ay; a_z_i = az; a_w_i = aw;
    b_x_i = bx; b_y_i = by; b_z_i = bz; b_w_i = bw;
    scalar_in_i = s;
    in_valid_i = 1'b1;
    do begin
      taken = !in_stall_o;
      @(negedge clk_i);
    end while (!taken);
  endtask

  // Component values: mostly full-range and modest magnitudes, with the
  // extremes, unity and zero mixed in.
  function automatic logic [31:0] pick_component();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      6:       return $urandom_range(32'h0000_0400) - 32'h0000_0200;
      7: begin
        case ($urandom_range(4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ONE;
          3: return -Q_ONE;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return 32'd0;
    endcase
  endfunction

  task automatic send_random_word();
    logic [3:0]  cmd;
    logic [31:0] av[4];
    cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    foreach (av[i]) av[i] = pick_component();
    // Zero-length vectors appear now and then for normalise and magnitude.
    if (cmd inside {CMD_NORM, CMD_MAG} && $urandom_range(7) == 0) av = '{default: '0};
    send_word(cmd, av[0], av[1], av[2], av[3], pick_component(), pick_component(),
              pick_component(), pick_component(), pick_component());
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed words: each command at least once, saturation at both ends, a zero
    // divisor, a zero-length normalise and unknown commands.
    send_word(CMD_ADD, Q_MAX, Q_MIN, Q_ONE, 0, Q_ONE, -1, Q_ONE, 0, 0);
    send_word(CMD_ADD, Q_MIN, 5, 7, -9, -1, 3, -2, 9, 0);
    send_word(CMD_SUB, Q_MIN, Q_MAX, 100, -100, 1, -1, 50, 50, 0);
    send_word(CMD_NEG, Q_MIN, Q_MAX, -Q_ONE, 0, 0, 0, 0, 0, 0);
    send_word(CMD_SCALE, Q_MAX, Q_MIN, -3, 3, 0, 0, 0, 0, Q_MAX);
    send_word(CMD_SCALE, Q_ONE, -Q_ONE, -1, 12345, 0, 0, 0, 0, 32'h0000_8000);
    send_word(CMD_DIV, Q_ONE, -Q_ONE, 0, Q_MAX, 0, 0, 0, 0, 0);
    send_word(CMD_DIV, Q_MAX, Q_MIN, -7, 7, 0, 0, 0, 0, 1);
    send_word(CMD_DIV, Q_MIN, 3 * Q_ONE, -5, 1, 0, 0, 0, 0, -1);
    send_word(CMD_DIV, 3 * Q_ONE, -3 * Q_ONE, 1, -1, 0, 0, 0, 0, 2 * Q_ONE);
    send_word(CMD_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0);
    send_word(CMD_DOT, Q_ONE, 2 * Q_ONE, -1, 0, Q_ONE, -Q_ONE, 1, Q_MIN, 0);
    send_word(CMD_CROSS, Q_ONE, 0, 0, Q_MAX, 0, Q_ONE, 0, Q_MAX, 0);
    send_word(CMD_CROSS, Q_MIN, Q_MAX, Q_MIN, 1, Q_MAX, Q_MIN, Q_MAX, 1, 0);
    send_word(CMD_MAG, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0);
    send_word(CMD_MAG, 3 * Q_ONE, 4 * Q_ONE, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_MAG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_NORM, 0, 0, 0, 0, 1, 2, 3, 4, 5);
    send_word(CMD_NORM, 3 * Q_ONE, 0, -4 * Q_ONE, 0, 0, 0, 0, 0, 0);
    send_word(CMD_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(CMD_NORM, Q_MIN, Q_MAX, 1, -1, 0, 0, 0, 0, 0);
    send_word(4'd9, Q_MAX, Q_MAX, 1, 1, 1, 1, 1, 1, Q_MAX);
    send_word(4'd15, Q_MIN, 1, 1, 1, 1, 1, 1, 1, 0);

    // Random phases: sender idles lightly and receiver heavily, then the
    // reverse, then neither idles but for one long receiver hold-off.
    repeat (250) send_random_word();

    // Sender pause until every outstanding result has drained.
    in_valid_i = 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    send_idle_pct = 67;
    recv_idle_pct = 16;
    repeat (250) send_random_word();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req = 1'b1;
    repeat (250) send_random_word();

    in_valid_i = 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
